// ===== rtl/pat_pkg.sv =====
// Shared types and constants for the packet ack tracker.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package pat_pkg;

	localparam int SEQ_W    = 16;
	localparam int TIME_W   = 32;
	localparam int BITS_W   = 32;
	localparam int RTT_W    = 48;
	localparam int SMOOTH_W = 16;
	localparam int FRAC_W   = 16;

	localparam logic [SEQ_W-1:0]    SEQ_HALF     = 16'h8000;
	localparam logic [SMOOTH_W-1:0] SMOOTH_RESET = 16'd164;

	localparam logic MODE_SEND = 1'b0;
	localparam logic MODE_RECV = 1'b1;
	localparam logic KIND_HDR  = 1'b0;
	localparam logic KIND_ACK  = 1'b1;

	// sent ring entry
	typedef struct packed {
		logic              valid;
		logic              acked;
		logic [SEQ_W-1:0]  seq;
		logic [TIME_W-1:0] stamp;
	} sent_ent_t;

	// received ring entry
	typedef struct packed {
		logic             valid;
		logic [SEQ_W-1:0] seq;
	} recv_ent_t;

	// controller to datapath
	typedef struct packed {
		logic clr;       // write one cleared entry, advance sweep index
		logic take;      // input transfer
		logic s_eval;    // shift one received mark into the header field
		logic hdr_load;  // load header into the output register
		logic advance;   // next window position of a receive item
		logic r_hit;     // mark sent entry acked, form rtt difference
		logic r_mul;     // scale the difference
		logic r_upd;     // update smoothed rtt
		logic r_push;    // park new ack result, emit the one parked before
		logic r_fin;     // emit the parked result as the final one
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic cnt_is_w;
		logic cnt_zero;
		logic cur_bit;
		logic hit;
		logic out_free;
		logic pend_valid;
	} sts_t;

endpackage

// ===== rtl/pat_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module pat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/pat_ctrl.sv =====
// Controller state machine of the packet ack tracker.
// Depends on pat_pkg for the command and status structs.
`timescale 1ns / 1ps

module pat_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_mode,
	output logic          in_stall,
	output pat_pkg::cmd_t cmd,
	input  pat_pkg::sts_t sts
);
	import pat_pkg::*;

	localparam logic [3:0] ST_CLEAR  = 4'd0;
	localparam logic [3:0] ST_IDLE   = 4'd1;
	localparam logic [3:0] ST_S_RD   = 4'd2;
	localparam logic [3:0] ST_S_EV   = 4'd3;
	localparam logic [3:0] ST_S_OUT  = 4'd4;
	localparam logic [3:0] ST_R_RD   = 4'd5;
	localparam logic [3:0] ST_R_EV   = 4'd6;
	localparam logic [3:0] ST_R_MUL  = 4'd7;
	localparam logic [3:0] ST_R_UPD  = 4'd8;
	localparam logic [3:0] ST_R_PUSH = 4'd9;
	localparam logic [3:0] ST_R_FIN  = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic [3:0] after_adv;

	assign in_stall  = (state_q != ST_IDLE);
	assign after_adv = sts.cnt_zero ? ST_R_FIN : ST_R_RD;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = (in_mode == MODE_RECV) ? ST_R_RD : ST_S_RD;
				end
			end
			ST_S_RD: begin
				state_d = ST_S_EV;
			end
			ST_S_EV: begin
				cmd.s_eval = 1'b1;
				state_d    = sts.cnt_is_w ? ST_S_OUT : ST_S_RD;
			end
			ST_S_OUT: begin
				if (sts.out_free) begin
					cmd.hdr_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_R_RD: begin
				if (sts.cur_bit) begin
					state_d = ST_R_EV;
				end else begin
					cmd.advance = 1'b1;
					state_d     = after_adv;
				end
			end
			ST_R_EV: begin
				if (sts.hit) begin
					cmd.r_hit = 1'b1;
					state_d   = ST_R_MUL;
				end else begin
					cmd.advance = 1'b1;
					state_d     = after_adv;
				end
			end
			ST_R_MUL: begin
				cmd.r_mul = 1'b1;
				state_d   = ST_R_UPD;
			end
			ST_R_UPD: begin
				cmd.r_upd = 1'b1;
				state_d   = ST_R_PUSH;
			end
			ST_R_PUSH: begin
				if (!sts.pend_valid || sts.out_free) begin
					cmd.r_push  = 1'b1;
					cmd.advance = 1'b1;
					state_d     = after_adv;
				end
			end
			ST_R_FIN: begin
				if (!sts.pend_valid) begin
					state_d = ST_IDLE;
				end else if (sts.out_free) begin
					cmd.r_fin = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/pat_dp.sv =====
// Datapath of the packet ack tracker: rings, sequence state, rtt filter, output register.
// Depends on pat_pkg and pat_ram.
`timescale 1ns / 1ps

module pat_dp #(
	parameter int RING_DEPTH = 1024,
	parameter int ACK_WINDOW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  pat_pkg::cmd_t cmd,
	output pat_pkg::sts_t sts,
	input  logic          cfg_we,
	input  logic [15:0]   cfg_wdata,
	input  logic          in_mode,
	input  logic [15:0]   in_rx_sequence,
	input  logic [15:0]   in_rx_ack,
	input  logic [31:0]   in_rx_ack_bits,
	input  logic [31:0]   in_now,
	input  logic          out_stall,
	output logic          out_valid,
	output logic          kind,
	output logic [15:0]   sequence_res,
	output logic [15:0]   ack,
	output logic [31:0]   ack_bits,
	output logic [47:0]   rtt_q16,
	output logic          last
);
	import pat_pkg::*;

	localparam int AW = $clog2(RING_DEPTH);
	localparam int CW = $clog2(ACK_WINDOW + 1);
	localparam int PW = RTT_W + SMOOTH_W;

	function automatic logic seq_newer(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
		logic [SEQ_W-1:0] d_ab;
		logic [SEQ_W-1:0] d_ba;
		d_ab = a - b;
		d_ba = b - a;
		return (a > b && d_ab <= SEQ_HALF) || (a < b && d_ba > SEQ_HALF);
	endfunction

	// control state
	logic [AW-1:0]       clr_idx_q;
	logic [SEQ_W-1:0]    next_seq_q;
	logic [SEQ_W-1:0]    newest_q;
	logic [RTT_W-1:0]    rtt_q;
	logic [SMOOTH_W-1:0] smooth_q;
	logic                pend_valid_q;
	logic                out_valid_q;

	// item and work registers
	logic [SEQ_W-1:0]    seq_q;
	logic [SEQ_W-1:0]    rx_ack_q;
	logic [BITS_W-1:0]   bits_q;
	logic [TIME_W-1:0]   now_q;
	logic [CW-1:0]       cnt_q;
	logic [BITS_W-1:0]   acc_q;
	logic [RTT_W-1:0]    sample_q;
	logic [RTT_W-1:0]    diff_q;
	logic                up_q;
	logic                repl_q;
	logic [PW-1:0]       prod_q;
	logic [SEQ_W-1:0]    pend_seq_q;
	logic [RTT_W-1:0]    pend_rtt_q;

	// output payload
	logic                kind_q;
	logic [SEQ_W-1:0]    seq_out_q;
	logic [SEQ_W-1:0]    ack_q;
	logic [BITS_W-1:0]   ack_bits_q;
	logic [RTT_W-1:0]    rtt_out_q;
	logic                last_q;

	// ring ports
	logic       sent_we;
	logic [AW-1:0] sent_waddr;
	sent_ent_t  sent_wdata;
	sent_ent_t  sent_rd;
	logic       recv_we;
	logic [AW-1:0] recv_waddr;
	recv_ent_t  recv_wdata;
	recv_ent_t  recv_rd;

	logic [SEQ_W-1:0]  t_send;
	logic [SEQ_W-1:0]  t_recv;
	logic              mark;
	logic              hit;
	logic              cnt_zero;
	logic              out_free;
	logic [TIME_W-1:0] ticks;
	logic [RTT_W-1:0]  sample;
	logic [RTT_W-1:0]  step;

	assign t_send   = newest_q - SEQ_W'(cnt_q);
	assign t_recv   = rx_ack_q - SEQ_W'(cnt_q);
	assign mark     = recv_rd.valid && (recv_rd.seq == t_send);
	assign hit      = sent_rd.valid && !sent_rd.acked && (sent_rd.seq == t_recv);
	assign cnt_zero = (cnt_q == '0);
	assign out_free = !out_valid_q || !out_stall;
	assign ticks    = now_q - sent_rd.stamp;
	assign sample   = {ticks, FRAC_W'(0)};
	assign step     = prod_q[PW-1:FRAC_W];

	assign sts.clr_last   = &clr_idx_q;
	assign sts.cnt_is_w   = (cnt_q == CW'(ACK_WINDOW));
	assign sts.cnt_zero   = cnt_zero;
	assign sts.cur_bit    = cnt_zero || bits_q[0];
	assign sts.hit        = hit;
	assign sts.out_free   = out_free;
	assign sts.pend_valid = pend_valid_q;

	// sent ring write: clear sweep, new send, ack mark
	always_comb begin
		sent_we    = 1'b0;
		sent_waddr = t_recv[AW-1:0];
		sent_wdata = sent_rd;
		if (cmd.clr) begin
			sent_we    = 1'b1;
			sent_waddr = clr_idx_q;
			sent_wdata = '0;
		end else if (cmd.take && in_mode == MODE_SEND) begin
			sent_we          = 1'b1;
			sent_waddr       = next_seq_q[AW-1:0];
			sent_wdata.valid = 1'b1;
			sent_wdata.acked = 1'b0;
			sent_wdata.seq   = next_seq_q;
			sent_wdata.stamp = in_now;
		end else if (cmd.r_hit) begin
			sent_we          = 1'b1;
			sent_wdata.acked = 1'b1;
		end
	end

	// received ring write: clear sweep, new receive
	always_comb begin
		recv_we    = 1'b0;
		recv_waddr = in_rx_sequence[AW-1:0];
		recv_wdata = '0;
		if (cmd.clr) begin
			recv_we    = 1'b1;
			recv_waddr = clr_idx_q;
		end else if (cmd.take && in_mode == MODE_RECV) begin
			recv_we          = 1'b1;
			recv_wdata.valid = 1'b1;
			recv_wdata.seq   = in_rx_sequence;
		end
	end

	pat_ram #(
		.WIDTH($bits(sent_ent_t)),
		.DEPTH(RING_DEPTH)
	) u_sent_ring (
		.clk  (clk),
		.we   (sent_we),
		.waddr(sent_waddr),
		.wdata(sent_wdata),
		.raddr(t_recv[AW-1:0]),
		.rdata(sent_rd)
	);

	pat_ram #(
		.WIDTH($bits(recv_ent_t)),
		.DEPTH(RING_DEPTH)
	) u_recv_ring (
		.clk  (clk),
		.we   (recv_we),
		.waddr(recv_waddr),
		.wdata(recv_wdata),
		.raddr(t_send[AW-1:0]),
		.rdata(recv_rd)
	);

	// sequence state, filter state, sweep index, config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q    <= '0;
			next_seq_q   <= '0;
			newest_q     <= '0;
			rtt_q        <= '0;
			smooth_q     <= SMOOTH_RESET;
			pend_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				smooth_q <= cfg_wdata;
			end
			if (cmd.clr) begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
			if (cmd.take) begin
				pend_valid_q <= 1'b0;
				if (in_mode == MODE_SEND) begin
					next_seq_q <= next_seq_q + 1'b1;
				end else if (seq_newer(in_rx_sequence, newest_q)) begin
					newest_q <= in_rx_sequence;
				end
			end
			if (cmd.r_upd) begin
				if (repl_q) begin
					rtt_q <= sample_q;
				end else if (up_q) begin
					rtt_q <= rtt_q + step;
				end else begin
					rtt_q <= rtt_q - step;
				end
			end
			if (cmd.r_push) begin
				pend_valid_q <= 1'b1;
			end else if (cmd.r_fin) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	// item capture, window walk, rtt difference and scaling
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			seq_q    <= next_seq_q;
			rx_ack_q <= in_rx_ack;
			bits_q   <= in_rx_ack_bits;
			now_q    <= in_now;
			acc_q    <= '0;
			cnt_q    <= (in_mode == MODE_RECV) ? CW'(ACK_WINDOW) : CW'(1);
		end
		if (cmd.s_eval) begin
			acc_q <= {acc_q[BITS_W-2:0], mark};
			cnt_q <= cnt_q + 1'b1;
		end
		if (cmd.advance) begin
			bits_q <= {1'b0, bits_q[BITS_W-1:1]};
			cnt_q  <= cnt_q - 1'b1;
		end
		if (cmd.r_hit) begin
			sample_q <= sample;
			repl_q   <= (rtt_q == '0 && sample != '0) || (rtt_q == sample);
			up_q     <= sample > rtt_q;
			diff_q   <= (sample > rtt_q) ? sample - rtt_q : rtt_q - sample;
		end
		if (cmd.r_mul) begin
			prod_q <= diff_q * smooth_q;
		end
		if (cmd.r_push) begin
			pend_seq_q <= t_recv;
			pend_rtt_q <= rtt_q;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.hdr_load || cmd.r_fin || (cmd.r_push && pend_valid_q)) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (cmd.hdr_load) begin
			kind_q     <= KIND_HDR;
			seq_out_q  <= seq_q;
			ack_q      <= newest_q;
			ack_bits_q <= acc_q;
			rtt_out_q  <= rtt_q;
			last_q     <= 1'b1;
		end else if (cmd.r_fin || (cmd.r_push && pend_valid_q)) begin
			kind_q     <= KIND_ACK;
			seq_out_q  <= pend_seq_q;
			ack_q      <= '0;
			ack_bits_q <= '0;
			rtt_out_q  <= pend_rtt_q;
			last_q     <= cmd.r_fin;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign sequence_res = seq_out_q;
	assign ack          = ack_q;
	assign ack_bits     = ack_bits_q;
	assign rtt_q16      = rtt_out_q;
	assign last         = last_q;

	// never overwrite a result that is still held
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.hdr_load || cmd.r_fin || (cmd.r_push && pend_valid_q)) |-> out_free)
		else $error("output register loaded while a result is held");

	// final emit drains the parked result
	a_fin_drains: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.r_fin |=> !pend_valid_q)
		else $error("parked result survived final emit");

	// newest received moves only on an input transfer
	a_newest_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.take |=> $stable(newest_q))
		else $error("newest received changed outside a transfer");

	// each send issues exactly the next sequence
	a_seq_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.take && in_mode == MODE_SEND) |=> next_seq_q == SEQ_W'($past(next_seq_q) + 1'b1))
		else $error("sequence counter did not step by one");

endmodule

// ===== rtl/packet_ack_tracker.sv =====
// Top level of the packet ack tracker: controller plus datapath.
// Depends on pat_pkg, pat_ctrl, pat_dp and pat_ram.
//
// Usage: one input channel (in_valid/in_stall) carries items. mode 0 sends a
// packet and gives one header result (kind 0): issued sequence, newest received
// sequence, ack field, current smoothed rtt. mode 1 records a received packet
// and gives one result (kind 1) per newly acknowledged sequence, oldest first,
// rx_ack last; last marks the final result of the item. A receive item that
// acknowledges nothing gives no result.
// A send reads and checks the ACK_WINDOW positions behind the newest received
// sequence in turn, loads its header into the output register and takes the next
// item in the cycle after that. A receive walks ACK_WINDOW + 1 window positions:
// an unmarked one takes only the read step, a marked one that is not acked adds
// the check, and a new ack goes through ring read, check, multiply, filter update
// and result park. One item is in work at a time; the next transfer is taken once
// the previous item's results are all handed to the output register. The ring
// memory read port and the rtt multiplier set this. Reset: a clearing pass empties
// both rings; no input is taken during it, configuration writes are. A stalled
// output holds its result and the block waits until the output register frees up.
`timescale 1ns / 1ps

module packet_ack_tracker #(
	parameter int RING_DEPTH = 1024,
	parameter int ACK_WINDOW = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic [15:0] rx_sequence,
	input  logic [15:0] rx_ack,
	input  logic [31:0] rx_ack_bits,
	input  logic [31:0] now,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic [15:0] sequence_res,
	output logic [15:0] ack,
	output logic [31:0] ack_bits,
	output logic [47:0] rtt_q16,
	output logic        last
);
	import pat_pkg::*;

	cmd_t cmd;
	sts_t sts;

	pat_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_mode (mode),
		.in_stall(in_stall),
		.cmd     (cmd),
		.sts     (sts)
	);

	pat_dp #(
		.RING_DEPTH(RING_DEPTH),
		.ACK_WINDOW(ACK_WINDOW)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_mode       (mode),
		.in_rx_sequence(rx_sequence),
		.in_rx_ack     (rx_ack),
		.in_rx_ack_bits(rx_ack_bits),
		.in_now        (now),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.kind          (kind),
		.sequence_res  (sequence_res),
		.ack           (ack),
		.ack_bits      (ack_bits),
		.rtt_q16       (rtt_q16),
		.last          (last)
	);

endmodule

// ===== sim/tb_packet_ack_tracker.sv =====
// Testbench for packet_ack_tracker: directed and random send/receive items,
// checked against a scoreboard that predicts headers, acks and the smoothed rtt.
// Depends on pat_pkg and the packet_ack_tracker RTL.
`timescale 1ns / 1ps

module tb_packet_ack_tracker;
	import pat_pkg::*;

	localparam int DEPTH     = 1024;
	localparam int WIN       = 32;
	localparam int TAIL      = 200;
	localparam int MAX_CYCLE = 1000000;

	typedef struct {
		logic        kind;
		logic [15:0] seq;
		logic [15:0] ack;
		logic [31:0] bits;
		logic [47:0] rtt;
		logic        last;
	} tracker_res_t;

	// link state mirror and queue of awaited results
	class ack_scoreboard;
		logic [15:0] smooth;
		logic [15:0] next_seq;
		logic [15:0] newest;
		logic [47:0] srtt;
		bit          s_valid [DEPTH];
		bit          s_acked [DEPTH];
		logic [15:0] s_seq [DEPTH];
		logic [31:0] s_time [DEPTH];
		bit          r_valid [DEPTH];
		logic [15:0] r_seq [DEPTH];
		tracker_res_t awaited[$];
		int          errors;

		function new();
			smooth = SMOOTH_RESET;
			next_seq = 0;
			newest = 0;
			srtt = 0;
			errors = 0;
			for (int i = 0; i < DEPTH; i++) begin
				s_valid[i] = 0;
				s_acked[i] = 0;
				r_valid[i] = 0;
			end
		endfunction

		function bit is_newer(logic [15:0] a, logic [15:0] b);
			logic [15:0] ab, ba;
			ab = a - b;
			ba = b - a;
			return (a > b && ab <= 16'h8000) || (a < b && ba > 16'h8000);
		endfunction

		function void filter_rtt(logic [31:0] ticks);
			logic [63:0] sample, d;
			sample = {16'd0, ticks, 16'd0};
			if ((srtt == 0 && sample != 0) || {16'd0, srtt} == sample) begin
				srtt = sample[47:0];
			end else if (sample > {16'd0, srtt}) begin
				d = sample - srtt;
				srtt = srtt + 48'((d * smooth) >> 16);
			end else begin
				d = srtt - sample;
				srtt = srtt - 48'((d * smooth) >> 16);
			end
		endfunction

		function bit take_ack(logic [15:0] sq, logic [31:0] t_now);
			int k;
			k = sq % DEPTH;
			if (!s_valid[k] || s_acked[k] || s_seq[k] != sq) return 0;
			s_acked[k] = 1;
			filter_rtt(t_now - s_time[k]);
			return 1;
		endfunction

		// predict the results of one accepted input transfer
		function void note_item(logic md, logic [15:0] rseq, logic [15:0] rack,
				logic [31:0] rbits, logic [31:0] t_now);
			tracker_res_t r, found[$];
			logic [15:0] t;
			int k;
			if (md == MODE_SEND) begin
				k = next_seq % DEPTH;
				s_valid[k] = 1;
				s_acked[k] = 0;
				s_seq[k] = next_seq;
				s_time[k] = t_now;
				r.kind = KIND_HDR;
				r.seq = next_seq;
				r.ack = newest;
				r.bits = 0;
				for (int i = 1; i <= WIN; i++) begin
					t = newest - 16'(i);
					r.bits = {r.bits[30:0], r_valid[t % DEPTH] && r_seq[t % DEPTH] == t};
				end
				r.rtt = srtt;
				r.last = 1;
				next_seq = next_seq + 16'd1;
				awaited = {awaited, r};
			end else begin
				if (is_newer(rseq, newest)) newest = rseq;
				r_valid[rseq % DEPTH] = 1;
				r_seq[rseq % DEPTH] = rseq;
				r.kind = KIND_ACK;
				r.ack = 0;
				r.bits = 0;
				r.last = 0;
				for (int i = WIN; i >= 0; i--) begin
					t = rack - 16'(i);
					if ((i == 0 || rbits[WIN - i]) && take_ack(t, t_now)) begin
						r.seq = t;
						r.rtt = srtt;
						found = {found, r};
					end
				end
				if (found.size() > 0) found[found.size() - 1].last = 1;
				awaited = {awaited, found};
			end
		endfunction

		// compare one output transfer with the oldest prediction
		function void check_result(tracker_res_t got);
			tracker_res_t e;
			if (awaited.size() == 0) begin
				$error("unexpected result: seq %0d", got.seq);
				errors++;
				return;
			end
			e = awaited.pop_front();
			if (got.kind !== e.kind) begin
				$error("kind: expected %0d actual %0d", e.kind, got.kind); errors++;
			end
			if (got.seq !== e.seq) begin
				$error("sequence_res: expected %0d actual %0d", e.seq, got.seq); errors++;
			end
			if (got.ack !== e.ack) begin
				$error("ack: expected %0d actual %0d", e.ack, got.ack); errors++;
			end
			if (got.bits !== e.bits) begin
				$error("ack_bits: expected %h actual %h", e.bits, got.bits); errors++;
			end
			if (got.rtt !== e.rtt) begin
				$error("rtt_q16: expected %h actual %h", e.rtt, got.rtt); errors++;
			end
			if (got.last !== e.last) begin
				$error("last: expected %0d actual %0d", e.last, got.last); errors++;
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic [15:0] cfg_wdata = 0;
	logic        in_valid = 0;
	logic        in_stall;
	logic        mode = 0;
	logic [15:0] rx_sequence = 0;
	logic [15:0] rx_ack = 0;
	logic [31:0] rx_ack_bits = 0;
	logic [31:0] now = 0;
	logic        out_valid;
	logic        out_stall = 0;
	logic        kind;
	logic [15:0] sequence_res;
	logic [15:0] ack;
	logic [31:0] ack_bits;
	logic [47:0] rtt_q16;
	logic        last;

	ack_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int recv_hold = 0;
	int cycles = 0;
	int sends = 0;
	logic [15:0] peer_seq = 16'hFFF0;
	logic [31:0] clock_ticks = 32'h0000_1000;

	packet_ack_tracker i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .mode(mode),
		.rx_sequence(rx_sequence), .rx_ack(rx_ack), .rx_ack_bits(rx_ack_bits),
		.now(now), .out_valid(out_valid), .out_stall(out_stall), .kind(kind),
		.sequence_res(sequence_res), .ack(ack), .ack_bits(ack_bits),
		.rtt_q16(rtt_q16), .last(last)
	);

	always #4 clk = ~clk;

	// stop a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > MAX_CYCLE) begin
			$display("status: fail");
			$finish;
		end
	end

	// drive receiver stall: long hold first, then random stalls
	always @(negedge clk) begin
		if (recv_hold > 0) begin
			out_stall = 1;
			recv_hold--;
		end else begin
			out_stall = ($urandom_range(99) < recv_stall_pct);
		end
	end

	// check every output transfer
	always @(posedge clk) begin
		tracker_res_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.kind = kind;
			got.seq = sequence_res;
			got.ack = ack;
			got.bits = ack_bits;
			got.rtt = rtt_q16;
			got.last = last;
			sb.check_result(got);
		end
	end

	// offer one item and hold it until the transfer
	task automatic push_item(logic md, logic [15:0] rseq, logic [15:0] rack,
			logic [31:0] rbits, logic [31:0] t_now);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 0;
			@(negedge clk);
		end
		in_valid = 1;
		mode = md;
		rx_sequence = rseq;
		rx_ack = rack;
		rx_ack_bits = rbits;
		now = t_now;
		do @(posedge clk); while (in_stall);
		sb.note_item(md, rseq, rack, rbits, t_now);
		if (md == MODE_SEND) sends++;
	endtask

	task automatic send_pkt(logic [31:0] t_now);
		push_item(MODE_SEND, 16'($urandom), 16'($urandom), $urandom, t_now);
	endtask

	task automatic recv_pkt(logic [15:0] rseq, logic [15:0] rack, logic [31:0] rbits,
			logic [31:0] t_now);
		push_item(MODE_RECV, rseq, rack, rbits, t_now);
	endtask

	// let the block drain, then write the smoothing register
	task automatic drain_and_set(logic [15:0] val);
		@(negedge clk);
		in_valid = 0;
		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (TAIL) @(posedge clk);
		@(negedge clk);
		cfg_we = 1;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we = 0;
		sb.smooth = val;
	endtask

	// mostly plausible link traffic with some noise
	task automatic random_items(int count);
		int pick;
		logic [31:0] bits;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			clock_ticks = clock_ticks + $urandom_range(1, 2000);
			if (pick < 45) begin
				send_pkt(clock_ticks);
			end else if (pick < 90 && sends > 0) begin
				bits = $urandom & $urandom;
				if ($urandom_range(3) == 0) bits = $urandom;
				peer_seq = peer_seq + (($urandom_range(4) == 0) ? 16'd2 : 16'd1);
				recv_pkt(peer_seq, 16'(sends - 1 - $urandom_range(0, 6)), bits,
					clock_ticks);
			end else begin
				push_item(1'($urandom_range(1)), 16'($urandom), 16'($urandom),
					$urandom, $urandom);
			end
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: time extremes, zero, replacing and equal samples, window edges
		send_pkt(32'h0000_0000);
		send_pkt(32'hFFFF_FFFF);
		recv_pkt(16'd0, 16'd0, 32'h0, 32'h0000_0000);
		recv_pkt(16'd1, 16'd1, 32'h0, 32'h0000_0005);
		send_pkt(32'd1000);
		recv_pkt(16'd2, 16'd2, 32'h0, 32'd1006);
		send_pkt(32'd10);
		send_pkt(32'd10);
		send_pkt(32'd10);
		recv_pkt(16'hFFFF, 16'd5, 32'hFFFF_FFFF, 32'd50);
		recv_pkt(16'h8000, 16'd5, 32'hFFFF_FFFF, 32'd60);
		recv_pkt(16'h7FFF, 16'hFFFF, 32'h0, 32'h0);
		send_pkt(32'h0);
		recv_pkt(16'd3, 16'd0, 32'h8000_0000, 32'h0);
		recv_pkt(16'd4, 16'd4, 32'h0000_0001, 32'h0);
		send_pkt(32'h8000_0000);
		recv_pkt(16'h7FFE, 16'd7, 32'h0, 32'hFFFF_FFFF);
		send_pkt(32'h0);

		// no idling, full-scale smoothing
		drain_and_set(16'hFFFF);
		random_items(45);

		// sender idle half the time, no smoothing
		send_idle_pct = 50;
		drain_and_set(16'h0000);
		random_items(45);

		// receiver stalls half the time
		send_idle_pct = 0;
		recv_stall_pct = 50;
		drain_and_set(16'h8000);
		random_items(45);

		// both sides idle now and then, plus a long receiver hold-off
		send_idle_pct = 17;
		recv_stall_pct = 17;
		drain_and_set(16'($urandom));
		recv_hold = 600;
		random_items(45);

		drain_and_set(SMOOTH_RESET);
		random_items(20);

		@(negedge clk);
		in_valid = 0;
		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (TAIL) @(posedge clk);
		if (sb.errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
